// ===== rtl/mvd_pkg.sv =====
package mvd_pkg;

    typedef enum logic [1:0] {
        OP_FILTER  = 2'd0,
        OP_DETECT  = 2'd1,
        OP_DRIFT   = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_BASE_X    = 3'd0,
        REG_BASE_Y    = 3'd1,
        REG_BASE_Z    = 3'd2,
        REG_START_THR = 3'd3,
        REG_FLOOR     = 3'd4,
        REG_CAP       = 3'd5,
        REG_GAIN      = 3'd6,
        REG_SHIFT     = 3'd7
    } reg_idx_t;

    localparam logic [7:0] PARK_EMPTY    = 8'd0;
    localparam logic [7:0] PARK_OCCUPIED = 8'd1;
    localparam logic [7:0] PARK_UNKNOWN  = 8'hFF;

    localparam logic [15:0] RST_START_THR = 16'd200;
    localparam logic [15:0] RST_FLOOR     = 16'd200;
    localparam logic [15:0] RST_CAP       = 16'd2000;
    localparam logic [3:0]  RST_GAIN      = 4'd4;
    localparam logic [2:0]  RST_SHIFT     = 3'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic signed [15:0] sample_z;
        logic [7:0]         park_status;
        logic               change_seen;
    } in_item_t;

    typedef struct packed {
        logic               wake;
        logic [2:0]         activity_score;
        logic signed [15:0] filtered_x;
        logic signed [15:0] filtered_y;
        logic signed [15:0] filtered_z;
        logic [15:0]        threshold_now;
        logic [15:0]        noise_level;
        logic signed [15:0] baseline_x_out;
        logic signed [15:0] baseline_y_out;
        logic signed [15:0] baseline_z_out;
        logic               drift_applied;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } cfg_item_t;

    // restart-time and filter settings handed to the back end
    typedef struct packed {
        logic signed [15:0] base_x;
        logic signed [15:0] base_y;
        logic signed [15:0] base_z;
        logic [15:0]        start_thr;
        logic [15:0]        floor_thr;
        logic [15:0]        cap_thr;
        logic [3:0]         gain;
        logic [2:0]         shift;
    } cfg_regs_t;

    // classified command from front to back
    typedef struct packed {
        op_t                op;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic               empty_mode;
        logic               occ_mode;
        logic               drift_ok;
    } cmd_t;

endpackage

// ===== rtl/mvd_if.sv =====
interface mvd_in_if;
    logic               valid;
    logic               ready;
    mvd_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mvd_out_if;
    logic               valid;
    logic               ready;
    mvd_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mvd_cfg_if;
    logic               valid;
    logic               ready;
    mvd_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mvd_front.sv =====
module mvd_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mvd_pkg::in_item_t   in_data,
    output logic                q_valid,
    input  logic                q_ready,
    output mvd_pkg::cmd_t       q_data
);

    localparam int DEPTH = 2;

    mvd_pkg::cmd_t cmd;
    mvd_pkg::cmd_t fifo_mem [DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push, pop;

    // sign-extend the low sample bits
    function automatic logic signed [15:0] sext(input logic [15:0] v);
        logic signed [SAMPLE_WIDTH-1:0] t;
        t = v[SAMPLE_WIDTH-1:0];
        return 16'(t);
    endfunction

    // classify the beat
    always_comb
    begin
        cmd.op         = mvd_pkg::op_t'(in_data.opcode);
        cmd.sx         = sext(in_data.sample_x);
        cmd.sy         = sext(in_data.sample_y);
        cmd.sz         = sext(in_data.sample_z);
        cmd.empty_mode = (in_data.park_status == mvd_pkg::PARK_EMPTY)
                      || (in_data.park_status == mvd_pkg::PARK_UNKNOWN);
        cmd.occ_mode   = !cmd.empty_mode
                      && ((in_data.park_status == mvd_pkg::PARK_OCCUPIED)
                      || in_data.change_seen);
        cmd.drift_ok   = (in_data.park_status == mvd_pkg::PARK_EMPTY)
                      && !in_data.change_seen;
    end

    assign in_ready = (count_reg != 2'(DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_data   = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH)) else $error("queue overfilled");
    a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'(DEPTH) && !pop) |=> (count_reg == 2'(DEPTH)))
        else $error("full queue lost an entry");

endmodule

// ===== rtl/mvd_back.sv =====
module mvd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  mvd_pkg::cmd_t       q_data,
    input  mvd_pkg::cfg_regs_t  cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output mvd_pkg::out_item_t  out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_OUT
    } state_t;

    state_t             state_reg;
    mvd_pkg::cmd_t      cmd_reg;

    logic signed [15:0] ema_reg [3];
    logic signed [15:0] base_reg [3];
    logic               seeded_reg;
    logic [15:0]        noise_reg;
    logic [15:0]        thr_reg;
    logic [2:0]         prev_reg;
    logic               calib_reg;
    logic               armed_reg;

    // pipeline scratch
    logic [17:0]        sum_reg;
    logic [17:0]        dsum_reg;
    logic [16:0]        d_reg [3];
    logic signed [16:0] err_reg [3];
    logic [18:0]        etot_reg;
    logic [23:0]        nacc_reg;
    logic [19:0]        tgt_reg;
    logic               wake_reg;
    logic [2:0]         score_reg;
    logic               drift_reg;

    logic signed [16:0] diff [3];
    logic signed [16:0] step [3];
    logic signed [15:0] ema_new [3];
    logic signed [16:0] res [3];
    logic [16:0]        absres [3];
    logic [16:0]        dabs [3];
    logic signed [16:0] errc [3];
    logic [16:0]        errabs [3];
    logic [15:0]        inst;
    logic [22:0]        sum5;
    logic [2:0]         score_c;
    logic [2:0]         lim;
    logic signed [16:0] adj [3];
    logic [15:0]        tgt_c;
    logic [18:0]        thr_sum;

    assign q_ready = (state_reg == ST_IDLE);

    // stage 1 arithmetic: ema step, distances, drift errors
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [15:0] sv;
            logic signed [16:0] q;
            sv = (i == 0) ? cmd_reg.sx : (i == 1) ? cmd_reg.sy : cmd_reg.sz;
            diff[i] = 17'(sv) - 17'(ema_reg[i]);
            q = diff[i] >>> cfg.shift;
            // round toward zero for negative remainders
            if (diff[i] < 0 && ((diff[i] & ~(-17'sd1 <<< cfg.shift)) != 0))
                q = q + 17'sd1;
            step[i]    = q;
            ema_new[i] = 16'(17'(ema_reg[i]) + step[i]);
            res[i]     = 17'(sv) - 17'(ema_new[i]);
            absres[i]  = res[i][16] ? 17'(-res[i]) : 17'(res[i]);
            dabs[i]    = (17'(base_reg[i]) - 17'(sv)) < 0
                       ? 17'(17'(sv) - 17'(base_reg[i]))
                       : 17'(17'(base_reg[i]) - 17'(sv));
            errc[i]    = 17'(ema_reg[i]) - 17'(base_reg[i]);
            errabs[i]  = errc[i][16] ? 17'(-errc[i]) : 17'(errc[i]);
        end
    end

    // stage 2 arithmetic: inst noise by a reciprocal of three, score, drift adjust
    always_comb
    begin
        logic [37:0] p;
        logic [17:0] r;
        p = 38'(sum_reg) * 38'd174763;
        r = 18'(p >> 19);
        if (18'(sum_reg) - 18'(r * 18'd3) >= 18'd3)
            r = r + 18'd1;
        inst = 16'(r);
        sum5 = 23'(noise_reg) * 23'd95 + 23'(inst) * 23'd5;
        score_c = 3'd0;
        if (cmd_reg.empty_mode)
        begin
            if (23'(dsum_reg) * 23'd20 >= 23'(thr_reg) * 23'd51)
                score_c = score_c + 3'd1;
            for (int i = 0; i < 3; i++)
            begin
                if (d_reg[i] >= 17'(thr_reg))
                begin
                    score_c = score_c + 3'd1;
                    if (18'(d_reg[i]) >= 18'(thr_reg) * 18'd3)
                        score_c = score_c + 3'd1;
                end
            end
        end
        else if (cmd_reg.occ_mode)
        begin
            for (int i = 0; i < 3; i++)
                if (d_reg[i] < 17'(thr_reg))
                    score_c = score_c + 3'd1;
        end
        lim = cmd_reg.empty_mode ? 3'd2 : 3'd3;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [16:0] a;
            a = err_reg[i] / 17'sd64;
            if (a > 17'sd50)
                a = 17'sd50;
            if (a < -17'sd50)
                a = -17'sd50;
            adj[i] = a;
        end
    end

    // stage 3 arithmetic: target clamp, smoothing
    always_comb
    begin
        logic [19:0] t;
        t = (tgt_reg > 20'd65535) ? 20'd65535 : tgt_reg;
        if (t < 20'(cfg.floor_thr))
            t = 20'(cfg.floor_thr);
        if (t > 20'(cfg.cap_thr))
            t = 20'(cfg.cap_thr);
        tgt_c   = 16'(t);
        thr_sum = 19'(thr_reg) * 19'd7 + 19'(tgt_c);
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                ema_reg[i]  <= '0;
                base_reg[i] <= '0;
            end
            seeded_reg <= 1'b0;
            noise_reg  <= '0;
            thr_reg    <= '0;
            prev_reg   <= '0;
            calib_reg  <= 1'b0;
            armed_reg  <= 1'b0;
            out_valid  <= 1'b0;
            wake_reg   <= 1'b0;
            score_reg  <= '0;
            drift_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_data;
                        state_reg <= ST_S1;
                    end
                end
                ST_S1:
                begin
                    wake_reg  <= 1'b0;
                    score_reg <= 3'd0;
                    drift_reg <= 1'b0;
                    sum_reg   <= 18'(absres[0]) + 18'(absres[1]) + 18'(absres[2]);
                    dsum_reg  <= 18'(dabs[0]) + 18'(dabs[1]) + 18'(dabs[2]);
                    etot_reg  <= 19'(errabs[0]) + 19'(errabs[1]) + 19'(errabs[2]);
                    for (int i = 0; i < 3; i++)
                    begin
                        d_reg[i]   <= dabs[i];
                        err_reg[i] <= errc[i];
                    end
                    if (cmd_reg.op == mvd_pkg::OP_RESTART)
                    begin
                        base_reg[0] <= cfg.base_x;
                        base_reg[1] <= cfg.base_y;
                        base_reg[2] <= cfg.base_z;
                        thr_reg     <= cfg.start_thr;
                        calib_reg   <= 1'b1;
                        seeded_reg  <= 1'b0;
                        noise_reg   <= '0;
                        state_reg   <= ST_OUT;
                        out_valid   <= 1'b1;
                    end
                    else if (calib_reg && cmd_reg.op == mvd_pkg::OP_FILTER)
                    begin
                        if (!seeded_reg)
                        begin
                            ema_reg[0] <= cmd_reg.sx;
                            ema_reg[1] <= cmd_reg.sy;
                            ema_reg[2] <= cmd_reg.sz;
                            seeded_reg <= 1'b1;
                            noise_reg  <= '0;
                            state_reg  <= ST_OUT;
                            out_valid  <= 1'b1;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                ema_reg[i] <= ema_new[i];
                            state_reg <= ST_S2;
                        end
                    end
                    else if (calib_reg && (cmd_reg.op == mvd_pkg::OP_DETECT
                        || (cmd_reg.op == mvd_pkg::OP_DRIFT && cmd_reg.drift_ok)))
                    begin
                        state_reg <= ST_S2;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                        out_valid <= 1'b1;
                    end
                end
                ST_S2:
                begin
                    unique case (cmd_reg.op)
                        mvd_pkg::OP_FILTER:
                        begin
                            nacc_reg  <= 24'(sum5);
                            state_reg <= ST_S3;
                        end
                        mvd_pkg::OP_DETECT:
                        begin
                            state_reg <= ST_OUT;
                            out_valid <= 1'b1;
                            score_reg <= score_c;
                            if (score_c >= lim && prev_reg >= lim)
                            begin
                                wake_reg <= 1'b1;
                                prev_reg <= 3'd0;
                            end
                            else
                            begin
                                prev_reg <= score_c;
                            end
                        end
                        mvd_pkg::OP_DRIFT:
                        begin
                            state_reg <= ST_OUT;
                            out_valid <= 1'b1;
                            if (!armed_reg)
                            begin
                                armed_reg <= 1'b1;
                            end
                            else if (22'(etot_reg) <= 22'(thr_reg) * 22'd6)
                            begin
                                for (int i = 0; i < 3; i++)
                                    base_reg[i] <= 16'(17'(base_reg[i]) + adj[i]);
                                drift_reg <= (adj[0] != 0) || (adj[1] != 0)
                                          || (adj[2] != 0);
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_OUT;
                            out_valid <= 1'b1;
                        end
                    endcase
                end
                ST_S3:
                begin
                    // noise /100 via reciprocal with one correction
                    logic [47:0] p;
                    logic [23:0] nq;
                    p  = 48'(nacc_reg) * 48'd10737419;
                    nq = 24'(p >> 30);
                    if (nacc_reg - 24'(nq * 24'd100) >= 24'd100)
                        nq = nq + 24'd1;
                    noise_reg <= 16'(nq);
                    tgt_reg   <= 20'(16'(nq)) * 20'(cfg.gain);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid)
                    begin
                        // threshold smoothing after target is ready
                        thr_reg   <= 16'(thr_sum >> 3);
                        out_valid <= 1'b1;
                    end
                    else if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        out_data.wake           = wake_reg;
        out_data.activity_score = score_reg;
        out_data.filtered_x     = ema_reg[0];
        out_data.filtered_y     = ema_reg[1];
        out_data.filtered_z     = ema_reg[2];
        out_data.threshold_now  = thr_reg;
        out_data.noise_level    = noise_reg;
        out_data.baseline_x_out = base_reg[0];
        out_data.baseline_y_out = base_reg[1];
        out_data.baseline_z_out = base_reg[2];
        out_data.drift_applied  = drift_reg;
    end

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_OUT)) else $error("result shown outside output state");
    a_wake_score: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.wake) |-> (out_data.activity_score >= 3'd2))
        else $error("wake without qualifying score");
    a_wake_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.wake) |-> (prev_reg == 3'd0))
        else $error("previous score kept after wake");

endmodule

// ===== rtl/magnetic_vehicle_detector.sv =====
// path: restart and non-acting beats go from S1 to OUT, detect and drift pass S1, S2 and OUT,
// filter update (seeded) passes S1, S2, S3 and a smoothing step in OUT, through the shared back end
// throughput: one beat at a time in the back end, a two-entry queue in front
// lets the next beat be taken while a result waits
// reset: rst_n asynchronous, clears control and filter state, not scratch; config registers take their defaults
module magnetic_vehicle_detector #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mvd_in_if.sink    in_ch,
    mvd_out_if.source out_ch,
    mvd_cfg_if.sink   cfg_ch
);

    mvd_pkg::cfg_regs_t cfg_reg;
    logic               q_valid;
    logic               q_ready;
    mvd_pkg::cmd_t      q_data;

    assign cfg_ch.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_x    <= '0;
            cfg_reg.base_y    <= '0;
            cfg_reg.base_z    <= '0;
            cfg_reg.start_thr <= mvd_pkg::RST_START_THR;
            cfg_reg.floor_thr <= mvd_pkg::RST_FLOOR;
            cfg_reg.cap_thr   <= mvd_pkg::RST_CAP;
            cfg_reg.gain      <= mvd_pkg::RST_GAIN;
            cfg_reg.shift     <= mvd_pkg::RST_SHIFT;
        end
        else if (cfg_ch.valid)
        begin
            unique case (mvd_pkg::reg_idx_t'(cfg_ch.data.index))
                mvd_pkg::REG_BASE_X:    cfg_reg.base_x    <= cfg_ch.data.data;
                mvd_pkg::REG_BASE_Y:    cfg_reg.base_y    <= cfg_ch.data.data;
                mvd_pkg::REG_BASE_Z:    cfg_reg.base_z    <= cfg_ch.data.data;
                mvd_pkg::REG_START_THR: cfg_reg.start_thr <= cfg_ch.data.data;
                mvd_pkg::REG_FLOOR:     cfg_reg.floor_thr <= cfg_ch.data.data;
                mvd_pkg::REG_CAP:       cfg_reg.cap_thr   <= cfg_ch.data.data;
                mvd_pkg::REG_GAIN:      cfg_reg.gain      <= cfg_ch.data.data[3:0];
                mvd_pkg::REG_SHIFT:     cfg_reg.shift     <= cfg_ch.data.data[2:0];
                default:                cfg_reg.shift     <= cfg_reg.shift;
            endcase
        end
    end

    mvd_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_data  (in_ch.data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    mvd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .cfg       (cfg_reg),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data)
    );

endmodule
